// File: src/mks_pkg.sv
// Shared field widths, stream packing widths and cell control type for the Morton key sorter.
package mks_pkg;

    // Fixed widths of the stream fields
    localparam int ID_FIELD_W    = 16;
    localparam int COORD_FIELD_W = 10;
    localparam int KEY_FIELD_W   = 30;
    localparam int RANK_FIELD_W  = 6;

    // Packed stream widths, padded to whole bytes
    localparam int S_FIELDS_W = ID_FIELD_W + 3 * COORD_FIELD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ID_FIELD_W + KEY_FIELD_W + RANK_FIELD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;     // place the new body in key order
        logic shift_out;  // move every entry one cell toward the head
    } cell_ctl_t;

endpackage

// File: src/mks_key_gen.sv
// Bit interleaver that forms the 3D Z-order key from x, y and z coordinates.
module mks_key_gen #(
    parameter int COORD_BITS = 10
) (
    input  logic [mks_pkg::COORD_FIELD_W-1:0] coord_x,
    input  logic [mks_pkg::COORD_FIELD_W-1:0] coord_y,
    input  logic [mks_pkg::COORD_FIELD_W-1:0] coord_z,
    output logic [3*COORD_BITS-1:0]           key
);

    // Spread coordinate bit b to key bits 3b, 3b+1, 3b+2; bits beyond the field read as zero
    for (genvar b = 0; b < COORD_BITS; b++) begin : g_bit
        if (b < mks_pkg::COORD_FIELD_W) begin : g_used
            assign key[3*b]   = coord_x[b];
            assign key[3*b+1] = coord_y[b];
            assign key[3*b+2] = coord_z[b];
        end else begin : g_zero
            assign key[3*b]   = 1'b0;
            assign key[3*b+1] = 1'b0;
            assign key[3*b+2] = 1'b0;
        end
    end

endmodule

// File: src/mks_cell.sv
// One cell of the insertion chain: holds a single (key, id) entry kept in ascending key order.
module mks_cell #(
    parameter int KEY_W = 30,
    parameter int ID_W  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mks_pkg::cell_ctl_t ctl,
    input  logic [KEY_W-1:0]   new_key,
    input  logic [ID_W-1:0]    new_id,
    input  logic               prev_gt,
    input  logic               prev_valid,
    input  logic [KEY_W-1:0]   prev_key,
    input  logic [ID_W-1:0]    prev_id,
    input  logic               next_valid,
    input  logic [KEY_W-1:0]   next_key,
    input  logic [ID_W-1:0]    next_id,
    output logic               valid,
    output logic [KEY_W-1:0]   key,
    output logic [ID_W-1:0]    id,
    output logic               gt
);

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [ID_W-1:0]  id_reg, id_next;

    // An empty cell counts as larger than any key; equal keys stay ahead of the new body
    assign gt = !valid_reg || (key_reg > new_key);

    // Pick the next entry: shift toward head, take from previous cell, take new body, or hold
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        id_next    = id_reg;
        if (ctl.shift_out)
        begin
            valid_next = next_valid;
            key_next   = next_key;
            id_next    = next_id;
        end
        else if (ctl.insert)
        begin
            if (prev_gt)
            begin
                valid_next = prev_valid;
                key_next   = prev_key;
                id_next    = prev_id;
            end
            else if (gt)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                id_next    = new_id;
            end
        end
    end

    // Hold the occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the entry payload
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign id    = id_reg;

endmodule

// File: src/morton_key_sort_top.sv
// Morton key sorter: loads bodies into a sorted cell chain and streams them out in key order.
// Load: one body per cycle, each placed in key order by the cell chain in the cycle it is taken.
// Output: the first result is valid in the cycle after the last_in transfer, then one per cycle
// while m_axis_tready is high, as the chain shifts toward its head.
// s_axis_tready is low while a set drains; the next set can start the cycle after the last result.
// Reset empties every cell and clears the drop flag; stored keys and ids are not cleared.
module morton_key_sort_top #(
    parameter int MAX_BODIES = 64,
    parameter int COORD_BITS = 10,
    parameter int ID_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // body_id[15:0], coord_x[25:16], coord_y[35:26], coord_z[45:36], zero pad
    input  logic [mks_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,   // last_in
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // sorted_id[15:0], order_key[45:16], rank[51:46], zero pad
    output logic [mks_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,   // overflow
    output logic                          m_axis_tlast    // last_out
);

    localparam int KEY_W  = 3 * COORD_BITS;
    localparam int RANK_W = $clog2(MAX_BODIES);
    localparam int IW     = mks_pkg::ID_FIELD_W;
    localparam int CW     = mks_pkg::COORD_FIELD_W;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              dropped_reg, dropped_next;

    logic [IW-1:0]      in_id;
    logic [CW-1:0]      in_x, in_y, in_z;
    logic [KEY_W-1:0]   new_key;
    logic [ID_BITS-1:0] new_id;

    logic               cell_valid [MAX_BODIES];
    logic [KEY_W-1:0]   cell_key   [MAX_BODIES];
    logic [ID_BITS-1:0] cell_id    [MAX_BODIES];
    logic               cell_gt    [MAX_BODIES];
    logic [MAX_BODIES-1:0] valid_vec;

    mks_pkg::cell_ctl_t ctl;
    logic               s_xfer, m_xfer, full;

    // Unpack the input fields
    assign in_id = s_axis_tdata[IW-1:0];
    assign in_x  = s_axis_tdata[IW+CW-1:IW];
    assign in_y  = s_axis_tdata[IW+2*CW-1:IW+CW];
    assign in_z  = s_axis_tdata[IW+3*CW-1:IW+2*CW];

    // Fit the id to the stored width
    if (ID_BITS <= IW) begin : g_id_trunc
        assign new_id = in_id[ID_BITS-1:0];
    end else begin : g_id_ext
        assign new_id = {{(ID_BITS-IW){1'b0}}, in_id};
    end

    mks_key_gen #(
        .COORD_BITS (COORD_BITS)
    ) u_key_gen (
        .coord_x (in_x),
        .coord_y (in_y),
        .coord_z (in_z),
        .key     (new_key)
    );

    // Handshakes and chain control
    assign full          = cell_valid[MAX_BODIES-1];
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_DRAIN) && cell_valid[0];
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_xfer        = m_axis_tvalid && m_axis_tready;
    assign ctl.insert    = s_xfer && !full;
    assign ctl.shift_out = m_xfer;

    // Build the chain; cell 0 holds the smallest key
    for (genvar i = 0; i < MAX_BODIES; i++) begin : g_cell
        logic               p_gt, p_valid, n_valid;
        logic [KEY_W-1:0]   p_key, n_key;
        logic [ID_BITS-1:0] p_id, n_id;

        if (i == 0) begin : g_head
            assign p_gt    = 1'b0;
            assign p_valid = 1'b0;
            assign p_key   = '0;
            assign p_id    = '0;
        end else begin : g_mid
            assign p_gt    = cell_gt[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_key   = cell_key[i-1];
            assign p_id    = cell_id[i-1];
        end

        if (i == MAX_BODIES - 1) begin : g_tail
            assign n_valid = 1'b0;
            assign n_key   = '0;
            assign n_id    = '0;
        end else begin : g_body
            assign n_valid = cell_valid[i+1];
            assign n_key   = cell_key[i+1];
            assign n_id    = cell_id[i+1];
        end

        mks_cell #(
            .KEY_W (KEY_W),
            .ID_W  (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_key    (new_key),
            .new_id     (new_id),
            .prev_gt    (p_gt),
            .prev_valid (p_valid),
            .prev_key   (p_key),
            .prev_id    (p_id),
            .next_valid (n_valid),
            .next_key   (n_key),
            .next_id    (n_id),
            .valid      (cell_valid[i]),
            .key        (cell_key[i]),
            .id         (cell_id[i]),
            .gt         (cell_gt[i])
        );

        assign valid_vec[i] = cell_valid[i];
    end

    // Drive the result stream from the head cell
    assign m_axis_tlast = !cell_valid[1];
    assign m_axis_tuser = dropped_reg;
    assign m_axis_tdata = {
        {(mks_pkg::M_TDATA_W - mks_pkg::M_FIELDS_W){1'b0}},
        mks_pkg::RANK_FIELD_W'(rank_reg),
        mks_pkg::KEY_FIELD_W'(cell_key[0]),
        mks_pkg::ID_FIELD_W'(cell_id[0])
    };

    // Sequence loading and draining, count ranks, track dropped bodies
    always_comb
    begin
        state_next   = state_reg;
        rank_next    = rank_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_xfer)
                begin
                    dropped_next = dropped_reg || full;
                    if (s_axis_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (m_xfer)
                begin
                    if (m_axis_tlast)
                    begin
                        state_next   = ST_LOAD;
                        rank_next    = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        rank_next = rank_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            rank_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rank_reg    <= rank_next;
            dropped_reg <= dropped_next;
        end
    end

`ifndef ASSERT_OFF
    // Draining always has a body at the head
    a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain state with empty head cell");

    // Occupied cells form an unbroken run from the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((({1'b0, valid_vec} + 1'b1) & {1'b0, valid_vec}) == '0))
        else $error("gap in occupied cells");

    // The final result reopens the input
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_xfer && m_axis_tlast) |=> (s_axis_tready && !cell_valid[0]))
        else $error("input not reopened after final result");

    // Ranks advance by one per transfer within a run
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_xfer && !m_axis_tlast) |=> (rank_reg == $past(rank_reg) + 1'b1))
        else $error("rank did not advance by one");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the Morton key sorter: streams body sets and checks sorted output.
`timescale 1ns / 1ps

module testbench;

    localparam int ID_FIELD_W    = mks_pkg::ID_FIELD_W;
    localparam int COORD_FIELD_W = mks_pkg::COORD_FIELD_W;
    localparam int KEY_FIELD_W   = mks_pkg::KEY_FIELD_W;
    localparam int RANK_FIELD_W  = mks_pkg::RANK_FIELD_W;
    localparam int S_TDATA_W     = mks_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = mks_pkg::M_TDATA_W;

    localparam int BODY_CAP     = 64;
    localparam int KEY_LSB      = ID_FIELD_W;
    localparam int RANK_LSB     = ID_FIELD_W + KEY_FIELD_W;
    localparam int X_LSB        = ID_FIELD_W;
    localparam int Y_LSB        = ID_FIELD_W + COORD_FIELD_W;
    localparam int Z_LSB        = ID_FIELD_W + 2 * COORD_FIELD_W;
    localparam int TARGET_ITEMS = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DIR_ROWS     = 18;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // One sorted body as it leaves the block
    typedef struct packed {
        logic [ID_FIELD_W-1:0]   id;
        logic [KEY_FIELD_W-1:0]  key;
        logic [RANK_FIELD_W-1:0] rank;
        logic                    ovf;
        logic                    last;
    } sorted_body_t;

    // One row of the directed table; exp_key is used only where typed is set
    typedef struct packed {
        logic [ID_FIELD_W-1:0]    id;
        logic [COORD_FIELD_W-1:0] x;
        logic [COORD_FIELD_W-1:0] y;
        logic [COORD_FIELD_W-1:0] z;
        logic                     last;
        logic                     typed;
        logic [KEY_FIELD_W-1:0]   exp_key;
    } body_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    // Predictor state: bodies of the current set in load order
    logic [KEY_FIELD_W-1:0] kept_key [BODY_CAP];
    logic [ID_FIELD_W-1:0]  kept_id  [BODY_CAP];
    int                     kept_count = 0;
    bit                     kept_dropped = 1'b0;

    sorted_body_t pending_sorted [$];

    int mismatches      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int sets_sent       = 0;
    int overflow_sets   = 0;
    int burst_left      = 1;
    int quiet_cycles    = 0;
    bit pause_for_results = 1'b0;
    bit hold_done         = 1'b0;

    body_row_t directed_rows [DIR_ROWS] = '{
        // single-body sets at the key extremes
        '{16'h0000, 10'h000, 10'h000, 10'h000, 1'b1, 1'b1, 30'h00000000},
        '{16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b1, 30'h3FFFFFFF},
        '{16'h0001, 10'h3FF, 10'h000, 10'h000, 1'b1, 1'b1, 30'h09249249},
        '{16'h0002, 10'h000, 10'h3FF, 10'h000, 1'b1, 1'b1, 30'h12492492},
        '{16'h0004, 10'h000, 10'h000, 10'h3FF, 1'b1, 1'b1, 30'h24924924},
        '{16'h8000, 10'h001, 10'h000, 10'h000, 1'b1, 1'b1, 30'h00000001},
        '{16'h7FFF, 10'h000, 10'h000, 10'h200, 1'b1, 1'b1, 30'h20000000},
        // equal keys must keep load order
        '{16'h000A, 10'h005, 10'h005, 10'h005, 1'b0, 1'b0, 30'h0},
        '{16'h000B, 10'h005, 10'h005, 10'h005, 1'b0, 1'b0, 30'h0},
        '{16'h000C, 10'h000, 10'h000, 10'h000, 1'b0, 1'b0, 30'h0},
        '{16'h000D, 10'h005, 10'h005, 10'h005, 1'b0, 1'b0, 30'h0},
        '{16'h000E, 10'h3FF, 10'h000, 10'h000, 1'b1, 1'b0, 30'h0},
        // loaded in descending key order
        '{16'h0014, 10'h007, 10'h007, 10'h007, 1'b0, 1'b0, 30'h0},
        '{16'h0015, 10'h003, 10'h003, 10'h003, 1'b0, 1'b0, 30'h0},
        '{16'h0016, 10'h001, 10'h000, 10'h000, 1'b0, 1'b0, 30'h0},
        '{16'h0017, 10'h000, 10'h000, 10'h000, 1'b1, 1'b0, 30'h0},
        // alternating bit patterns
        '{16'h001E, 10'h155, 10'h2AA, 10'h155, 1'b0, 1'b0, 30'h0},
        '{16'h001F, 10'h2AA, 10'h155, 10'h2AA, 1'b1, 1'b0, 30'h0}
    };

    morton_key_sort_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Spread coordinate bits: x to 3i, y to 3i+1, z to 3i+2
    function automatic logic [KEY_FIELD_W-1:0] morton_interleave(
        input logic [COORD_FIELD_W-1:0] x,
        input logic [COORD_FIELD_W-1:0] y,
        input logic [COORD_FIELD_W-1:0] z
    );
        logic [KEY_FIELD_W-1:0] k;
        k = '0;
        for (int b = 0; b < COORD_FIELD_W; b++)
        begin
            k[3 * b]     = x[b];
            k[3 * b + 1] = y[b];
            k[3 * b + 2] = z[b];
        end
        return k;
    endfunction

    // Keep one body; on the set's last body emit the set sorted by key when emit is set
    task automatic load_body(
        input logic [ID_FIELD_W-1:0]    id,
        input logic [COORD_FIELD_W-1:0] x,
        input logic [COORD_FIELD_W-1:0] y,
        input logic [COORD_FIELD_W-1:0] z,
        input logic                     last,
        input bit                       emit
    );
        int           order [BODY_CAP];
        int           j;
        sorted_body_t r;
        if (kept_count < BODY_CAP)
        begin
            kept_key[kept_count] = morton_interleave(x, y, z);
            kept_id[kept_count]  = id;
            kept_count++;
        end
        else
            kept_dropped = 1'b1;
        if (!last)
            return;
        // stable insertion sort: strictly greater keys move up, ties stay put
        for (int i = 0; i < kept_count; i++)
        begin
            j = i;
            while (j > 0 && kept_key[order[j - 1]] > kept_key[i])
            begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = i;
        end
        if (kept_dropped)
            overflow_sets++;
        for (int i = 0; i < kept_count; i++)
        begin
            r.id   = kept_id[order[i]];
            r.key  = kept_key[order[i]];
            r.rank = i[RANK_FIELD_W-1:0];
            r.ovf  = kept_dropped;
            r.last = (i == kept_count - 1);
            if (emit)
                pending_sorted = {pending_sorted, r};
        end
        kept_count   = 0;
        kept_dropped = 1'b0;
        sets_sent++;
    endtask

    // Offer one body, wait for its transfer, then keep bursting or go idle
    task automatic send_body(
        input logic [ID_FIELD_W-1:0]    id,
        input logic [COORD_FIELD_W-1:0] x,
        input logic [COORD_FIELD_W-1:0] y,
        input logic [COORD_FIELD_W-1:0] z,
        input logic                     last,
        input bit                       typed,
        input sorted_body_t             typed_res
    );
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[0 +: ID_FIELD_W]        = id;
        word[X_LSB +: COORD_FIELD_W] = x;
        word[Y_LSB +: COORD_FIELD_W] = y;
        word[Z_LSB +: COORD_FIELD_W] = z;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        load_body(id, x, y, z, last, !typed);
        if (typed)
            pending_sorted = {pending_sorted, typed_res};
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 || pause_for_results)
        begin
            s_axis_tvalid <= 1'b0;
            if (pause_for_results)
            begin
                // hold off until the block has delivered everything
                do
                    @(posedge clk);
                while (pending_sorted.size() != 0);
                pause_for_results = 1'b0;
            end
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 100);
            else
                burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Receiver: stall on a changing pattern, with one long hold-off mid-run
    initial
    begin : receiver
        rx_mode_t rx_mode;
        int       mode_left;
        int       tick;
        rx_mode   = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (!hold_done && rst_n && m_axis_tvalid && results_checked >= 40)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS:   m_axis_tready <= 1'b1;
                    RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_axis_tready <= (tick % 5 != 0);
                    default:     m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        sorted_body_t got;
        sorted_body_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.id   = m_axis_tdata[0 +: ID_FIELD_W];
            got.key  = m_axis_tdata[KEY_LSB +: KEY_FIELD_W];
            got.rank = m_axis_tdata[RANK_LSB +: RANK_FIELD_W];
            got.ovf  = m_axis_tuser;
            got.last = m_axis_tlast;
            if (pending_sorted.size() == 0)
                report_mismatch("result with nothing pending, id", 64'(got.id), '0);
            else
            begin
                want = pending_sorted.pop_front();
                if (got.id !== want.id)
                    report_mismatch("sorted_id", 64'(got.id), 64'(want.id));
                if (got.key !== want.key)
                    report_mismatch("order_key", 64'(got.key), 64'(want.key));
                if (got.rank !== want.rank)
                    report_mismatch("rank", 64'(got.rank), 64'(want.rank));
                if (got.ovf !== want.ovf)
                    report_mismatch("overflow", 64'(got.ovf), 64'(want.ovf));
                if (got.last !== want.last)
                    report_mismatch("last_out", 64'(got.last), 64'(want.last));
            end
            results_checked++;
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        sorted_body_t             typed_res;
        body_row_t                row;
        logic [COORD_FIELD_W-1:0] x;
        logic [COORD_FIELD_W-1:0] y;
        logic [COORD_FIELD_W-1:0] z;
        int                       set_size;
        int                       set_idx;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row            = directed_rows[r];
            typed_res.id   = row.id;
            typed_res.key  = row.exp_key;
            typed_res.rank = '0;
            typed_res.ovf  = 1'b0;
            typed_res.last = 1'b1;
            send_body(row.id, row.x, row.y, row.z, row.last, row.typed, typed_res);
        end

        // random sets: mostly small, a full one and a few past capacity
        set_idx = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (set_idx == 3)
                set_size = BODY_CAP;
            else if (set_idx == 8)
                set_size = BODY_CAP + 1;
            else if (set_idx == 15)
                set_size = BODY_CAP + 6;
            else
                set_size = $urandom_range(1, 10);
            for (int i = 0; i < set_size; i++)
            begin
                // low coordinates make key ties likely
                if ($urandom_range(0, 3) == 0)
                begin
                    x = COORD_FIELD_W'($urandom_range(0, 1));
                    y = COORD_FIELD_W'($urandom_range(0, 1));
                    z = COORD_FIELD_W'($urandom_range(0, 1));
                end
                else
                begin
                    x = COORD_FIELD_W'($urandom_range(0, 1023));
                    y = COORD_FIELD_W'($urandom_range(0, 1023));
                    z = COORD_FIELD_W'($urandom_range(0, 1023));
                end
                if (set_idx == 20 && i == set_size - 1)
                    pause_for_results = 1'b1;
                send_body(ID_FIELD_W'($urandom_range(0, 65535)), x, y, z, i == set_size - 1,
                          1'b0, '0);
            end
            set_idx++;
        end

        // drain and let the block settle
        s_axis_tvalid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bodies in %0d sets; checked %0d sorted results.",
                 items_sent, sets_sent, results_checked);
        $display("%0d sets exceeded capacity; one long output stall of %0d cycles.",
                 overflow_sets, HOLD_CYCLES);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
